/* rtl/radio_api_tx_frame_builder_macros.svh */
// Assertion macros for the transmit frame builder.
// Used by rtfb_cmd_fifo and rtfb_back; no other dependencies.
`ifndef RADIO_API_TX_FRAME_BUILDER_MACROS_SVH
`define RADIO_API_TX_FRAME_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RTFB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rtfb assertion failed");
// Condition must never be true outside reset.
`define RTFB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rtfb forbidden condition seen");
`else
`define RTFB_ASSERT(lbl, clk, rst_n, prop)
`define RTFB_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/rtfb_pkg.sv */
// Shared types and constants of the transmit frame builder.
// No dependencies.
package rtfb_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd100;
    localparam logic [8:0] LEN_OVERHEAD = 9'd5;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Command kinds passed from the front to the back
    localparam logic [1:0] CMD_PAYLOAD = 2'd0;
    localparam logic [1:0] CMD_HEADER  = 2'd1;
    localparam logic [1:0] CMD_ERROR   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_DELIM = 2'd0;
    localparam logic [1:0] CFG_FRAME_TYPE  = 2'd1;
    localparam logic [1:0] CFG_FRAME_ID    = 2'd2;
    localparam logic [1:0] CFG_TX_OPTIONS  = 2'd3;

    localparam logic [7:0] RST_START_DELIM = 8'h7E;
    localparam logic [7:0] RST_FRAME_TYPE  = 8'h01;
    localparam logic [7:0] RST_FRAME_ID    = 8'h00;
    localparam logic [7:0] RST_TX_OPTIONS  = 8'h00;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last_item;
        logic [7:0]  payload_len;
        logic [15:0] dest_addr;
    } t_cmd;

endpackage

/* rtl/rtfb_cmd_fifo.sv */
// Command queue between the front classifier and the back sequencer.
// Depends on rtfb_pkg and the assertion macro header.
`include "radio_api_tx_frame_builder_macros.svh"

module rtfb_cmd_fifo
    import rtfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_head_valid,
    output t_cmd o_head_cmd
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]   r_count, n_count;

    assign o_ready      = (r_count != (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(i_pop);
        n_count  = r_count + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    `RTFB_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && !o_ready && !i_pop)
    `RTFB_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_head_valid)
    `RTFB_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

/* rtl/rtfb_front.sv */
// Front end: accepts input beats, tracks frame state and queues commands.
// Depends on rtfb_pkg and rtfb_cmd_fifo.
module rtfb_front
    import rtfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_first_item,
    input  logic        i_last_item,
    input  logic [7:0]  i_payload_len,
    input  logic [15:0] i_dest_addr,
    input  logic        i_pop,
    output logic        o_head_valid,
    output t_cmd        o_head_cmd
);

    logic r_in_frame, n_in_frame;
    logic r_dropping, n_dropping;
    logic accept;
    logic push;
    t_cmd push_cmd;

    assign accept = i_valid && o_ready;

    always_comb begin
        n_in_frame            = r_in_frame;
        n_dropping            = r_dropping;
        push                  = 1'b0;
        push_cmd.kind         = CMD_PAYLOAD;
        push_cmd.payload_byte = i_payload_byte;
        push_cmd.last_item    = i_last_item;
        push_cmd.payload_len  = i_payload_len;
        push_cmd.dest_addr    = i_dest_addr;
        if (accept) begin
            if (i_first_item) begin
                push = 1'b1;
                if (i_payload_len > MAX_PAYLOAD) begin
                    // drop the rest of this frame up to its last beat
                    push_cmd.kind = CMD_ERROR;
                    n_in_frame    = 1'b0;
                    n_dropping    = !i_last_item;
                end else begin
                    push_cmd.kind = CMD_HEADER;
                    n_in_frame    = (i_payload_len != 8'd0) && !i_last_item;
                    n_dropping    = 1'b0;
                end
            end else if (r_dropping) begin
                n_dropping = !i_last_item;
            end else if (r_in_frame) begin
                push       = 1'b1;
                n_in_frame = !i_last_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_dropping <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_dropping <= n_dropping;
        end
    end

    rtfb_cmd_fifo u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_ready      (o_ready),
        .i_pop        (i_pop),
        .o_head_valid (o_head_valid),
        .o_head_cmd   (o_head_cmd)
    );

endmodule

/* rtl/rtfb_back.sv */
// Back end: expands queued commands into output bytes and keeps the checksum.
// Depends on rtfb_pkg and the assertion macro header.
`include "radio_api_tx_frame_builder_macros.svh"

module rtfb_back
    import rtfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_head_valid,
    input  t_cmd       i_head_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_err
);

    localparam logic [3:0] STEP_DELIM   = 4'd0;
    localparam logic [3:0] STEP_LEN_HI  = 4'd1;
    localparam logic [3:0] STEP_LEN_LO  = 4'd2;
    localparam logic [3:0] STEP_TYPE    = 4'd3;
    localparam logic [3:0] STEP_ID      = 4'd4;
    localparam logic [3:0] STEP_DEST_HI = 4'd5;
    localparam logic [3:0] STEP_DEST_LO = 4'd6;
    localparam logic [3:0] STEP_OPTIONS = 4'd7;
    localparam logic [3:0] STEP_PAYLOAD = 4'd8;
    localparam logic [3:0] STEP_CSUM    = 4'd9;

    logic [7:0] r_start_delim, r_frame_type, r_frame_id, r_tx_options;
    logic [3:0] r_step, n_step;
    logic [7:0] r_sum, n_sum;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last, r_out_err;

    logic       load, emit, done, add, set_sum;
    logic [7:0] gen_byte;
    logic       gen_last, gen_err;
    logic [8:0] total_len;

    assign total_len = {1'b0, i_head_cmd.payload_len} + LEN_OVERHEAD;
    assign load      = i_head_valid && (!r_out_valid || i_ready);
    assign o_pop     = load && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= RST_START_DELIM;
            r_frame_type  <= RST_FRAME_TYPE;
            r_frame_id    <= RST_FRAME_ID;
            r_tx_options  <= RST_TX_OPTIONS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_DELIM: r_start_delim <= i_cfg_data;
                CFG_FRAME_TYPE:  r_frame_type  <= i_cfg_data;
                CFG_FRAME_ID:    r_frame_id    <= i_cfg_data;
                CFG_TX_OPTIONS:  r_tx_options  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        emit     = 1'b1;
        done     = 1'b0;
        add      = 1'b0;
        set_sum  = 1'b0;
        gen_byte = 8'h00;
        gen_last = 1'b0;
        gen_err  = 1'b0;
        unique case (i_head_cmd.kind)
            CMD_ERROR: begin
                gen_last = 1'b1;
                gen_err  = 1'b1;
                done     = 1'b1;
            end
            CMD_PAYLOAD: begin
                if (r_step == STEP_DELIM) begin
                    gen_byte = i_head_cmd.payload_byte;
                    add      = 1'b1;
                    done     = !i_head_cmd.last_item;
                end else begin
                    gen_byte = ~r_sum;
                    gen_last = 1'b1;
                    done     = 1'b1;
                end
            end
            CMD_HEADER: begin
                unique case (r_step)
                    STEP_DELIM:   gen_byte = r_start_delim;
                    STEP_LEN_HI:  gen_byte = {7'd0, total_len[8]};
                    STEP_LEN_LO:  gen_byte = total_len[7:0];
                    STEP_TYPE: begin
                        gen_byte = r_frame_type;
                        set_sum  = 1'b1;
                    end
                    STEP_ID: begin
                        gen_byte = r_frame_id;
                        add      = 1'b1;
                    end
                    STEP_DEST_HI: begin
                        gen_byte = i_head_cmd.dest_addr[15:8];
                        add      = 1'b1;
                    end
                    STEP_DEST_LO: begin
                        gen_byte = i_head_cmd.dest_addr[7:0];
                        add      = 1'b1;
                    end
                    STEP_OPTIONS: begin
                        gen_byte = r_tx_options;
                        add      = 1'b1;
                    end
                    STEP_PAYLOAD: begin
                        if (i_head_cmd.payload_len == 8'd0) begin
                            // empty frame: checksum follows the options byte
                            gen_byte = ~r_sum;
                            gen_last = 1'b1;
                            done     = 1'b1;
                        end else begin
                            gen_byte = i_head_cmd.payload_byte;
                            add      = 1'b1;
                            done     = !i_head_cmd.last_item;
                        end
                    end
                    STEP_CSUM: begin
                        gen_byte = ~r_sum;
                        gen_last = 1'b1;
                        done     = 1'b1;
                    end
                    default: begin
                        emit = 1'b0;
                        done = 1'b1;
                    end
                endcase
            end
            default: begin
                emit = 1'b0;
                done = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_step      = r_step;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !i_ready;
        if (load) begin
            n_step = done ? STEP_DELIM : r_step + 4'd1;
            if (set_sum) begin
                n_sum = gen_byte;
            end else if (add) begin
                n_sum = r_sum + gen_byte;
            end
            if (emit) begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_DELIM;
            r_sum       <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && emit) begin
            r_out_byte <= gen_byte;
            r_out_last <= gen_last;
            r_out_err  <= gen_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_err   = r_out_err;

    `RTFB_ASSERT(a_err_is_last, i_clk, i_rst_n, (r_out_valid && r_out_err) |-> r_out_last)
    `RTFB_ASSERT(a_mid_cmd_held, i_clk, i_rst_n, (r_step != STEP_DELIM) |-> i_head_valid)
    `RTFB_ASSERT(a_payload_steps, i_clk, i_rst_n,
        (i_head_valid && i_head_cmd.kind == CMD_PAYLOAD) |-> (r_step <= STEP_LEN_HI))
    `RTFB_ASSERT_NEVER(a_err_no_step, i_clk, i_rst_n,
        i_head_valid && i_head_cmd.kind == CMD_ERROR && r_step != STEP_DELIM)

endmodule

/* rtl/radio_api_tx_frame_builder.sv */
// Transmit frame builder, top level: a front end that classifies input beats
// into commands, an 8-entry command queue and a back end that emits the bytes.
// A payload beat gives one output byte (two when it closes the frame, for the
// checksum); the first beat of a frame gives nine or ten bytes with the
// header. The back end's output register sets the pace at one byte per cycle
// while m_axis_tready is high, and the 8-command queue lets up to seven
// payload beats enter at one per cycle while the header goes out. An oversized
// length gives one error beat and the rest of that frame is dropped at the
// input without output. Configuration writes apply to every header byte not
// yet emitted, so make them while the block is idle.
module radio_api_tx_frame_builder
    import rtfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [7:0] payload_byte, [15:8] payload_len,
                                       // [31:16] dest_addr
    input  logic        s_axis_tlast,  // last_item
    input  logic        s_axis_tuser,  // [0] first_item
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast,  // out_last
    output logic        m_axis_tuser   // [0] length_error
);

    logic head_valid;
    logic pop;
    t_cmd head_cmd;

    rtfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_payload_byte (s_axis_tdata[7:0]),
        .i_first_item   (s_axis_tuser),
        .i_last_item    (s_axis_tlast),
        .i_payload_len  (s_axis_tdata[15:8]),
        .i_dest_addr    (s_axis_tdata[31:16]),
        .i_pop          (pop),
        .o_head_valid   (head_valid),
        .o_head_cmd     (head_cmd)
    );

    rtfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head_cmd   (head_cmd),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_err        (m_axis_tuser)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for radio_api_tx_frame_builder: sends payload beats,
// predicts every framed byte in-bench and compares each output beat in order.
// Depends on rtfb_pkg and the frame builder RTL only.
module tb;
    import rtfb_pkg::*;

    typedef struct packed {
        logic [7:0]  pbyte;
        logic        is_first;
        logic        is_last;
        logic [7:0]  plen;
        logic [15:0] dest;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
        logic       err;
    } t_out_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [7:0] payload_byte, [15:8] payload_len, [31:16] dest_addr
    logic        s_axis_tlast;   // last_item
    logic        s_axis_tuser;   // [0] first_item
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tlast;   // out_last
    logic        m_axis_tuser;   // [0] length_error

    // Bench copy of the registers and the framing state
    logic [7:0]  reg_delim, reg_type, reg_id, reg_opts;
    logic        open_frame, drop_frame;
    logic [7:0]  csum_acc;
    t_out_beat   frame_bytes_q[$];

    int n_mismatch = 0;
    int n_live = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    radio_api_tx_frame_builder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out_beat mk_out(logic [7:0] data, logic is_last, logic err);
        t_out_beat o;
        o.data    = data;
        o.is_last = is_last;
        o.err     = err;
        return o;
    endfunction

    function automatic t_in_beat mk_beat(logic [7:0] pbyte, logic is_first, logic is_last,
                                         logic [7:0] plen, logic [15:0] dest);
        t_in_beat b;
        b.pbyte    = pbyte;
        b.is_first = is_first;
        b.is_last  = is_last;
        b.plen     = plen;
        b.dest     = dest;
        return b;
    endfunction

    function automatic void push_byte(logic [7:0] b, bit summed);
        if (summed) begin
            csum_acc = csum_acc + b;
        end
        frame_bytes_q.push_back(mk_out(b, 1'b0, 1'b0));
    endfunction

    function automatic void push_checksum();
        frame_bytes_q.push_back(mk_out(8'hFF - csum_acc, 1'b1, 1'b0));
        open_frame = 1'b0;
    endfunction

    // Queue the bytes that one input beat causes; returns 1 unless the beat
    // is simply swallowed (stray or part of a dropped frame).
    function automatic bit predict_frame_bytes(t_in_beat b);
        logic [8:0] total;
        if (b.is_first) begin
            open_frame = 1'b0;
            drop_frame = 1'b0;
            if (b.plen > MAX_PAYLOAD) begin
                drop_frame = !b.is_last;
                frame_bytes_q.push_back(mk_out(8'h00, 1'b1, 1'b1));
                return 1'b1;
            end
            total    = {1'b0, b.plen} + LEN_OVERHEAD;
            csum_acc = 8'h00;
            push_byte(reg_delim, 1'b0);
            push_byte({7'd0, total[8]}, 1'b0);
            push_byte(total[7:0], 1'b0);
            push_byte(reg_type, 1'b1);
            push_byte(reg_id, 1'b1);
            push_byte(b.dest[15:8], 1'b1);
            push_byte(b.dest[7:0], 1'b1);
            push_byte(reg_opts, 1'b1);
            if (b.plen == 8'd0) begin
                push_checksum();
            end else begin
                push_byte(b.pbyte, 1'b1);
                if (b.is_last) begin
                    push_checksum();
                end else begin
                    open_frame = 1'b1;
                end
            end
            return 1'b1;
        end
        if (drop_frame) begin
            if (b.is_last) begin
                drop_frame = 1'b0;
            end
            return 1'b0;
        end
        if (!open_frame) begin
            return 1'b0;
        end
        push_byte(b.pbyte, 1'b1);
        if (b.is_last) begin
            push_checksum();
        end
        return 1'b1;
    endfunction

    task automatic send_beat(t_in_beat b);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.dest, b.plen, b.pbyte};
        s_axis_tlast  <= b.is_last;
        s_axis_tuser  <= b.is_first;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (predict_frame_bytes(b)) begin
            n_live++;
        end
    endtask

    // n beats, the first carrying length and destination; close marks the
    // final beat as last
    task automatic send_frame(logic [7:0] plen, logic [15:0] dest, int n, bit close);
        for (int i = 0; i < n; i++) begin
            send_beat(mk_beat(8'($urandom_range(255)), i == 0, close && (i == n - 1),
                              (i == 0) ? plen : 8'($urandom_range(255)),
                              (i == 0) ? dest : 16'($urandom_range(65535))));
        end
    endtask

    // Hold the input low until every predicted byte is out, then let
    // swallowed beats clear the pipeline.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (frame_bytes_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_START_DELIM: reg_delim = val;
            CFG_FRAME_TYPE:  reg_type  = val;
            CFG_FRAME_ID:    reg_id    = val;
            CFG_TX_OPTIONS:  reg_opts  = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [7:0] delim, logic [7:0] ftype, logic [7:0] fid,
                             logic [7:0] opts);
        write_reg(CFG_START_DELIM, delim);
        write_reg(CFG_FRAME_TYPE, ftype);
        write_reg(CFG_FRAME_ID, fid);
        write_reg(CFG_TX_OPTIONS, opts);
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_frame();
        int pick;
        int sel;
        int len;
        pick = $urandom_range(99);
        if (pick < 78) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                len = $urandom_range(8);
            end else if (sel < 98) begin
                len = $urandom_range(30, 9);
            end else begin
                len = $urandom_range(100, 80);
            end
            send_frame(8'(len), 16'($urandom_range(65535)), (len == 0) ? 1 : len,
                       (len == 0) ? 1'($urandom_range(1)) : 1'b1);
        end else if (pick < 86) begin
            send_frame(8'($urandom_range(255, 101)), 16'($urandom_range(65535)),
                       $urandom_range(4, 1), 1'b1);
        end else if (pick < 90) begin
            send_beat(mk_beat(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                              8'($urandom_range(255)), 16'($urandom_range(65535))));
        end else begin
            // count off or left open for the next frame to abandon
            send_frame(8'($urandom_range(12, 1)), 16'($urandom_range(65535)),
                       $urandom_range(14, 1), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_defaults();
        send_beat(mk_beat(8'hFF, 1'b1, 1'b0, 8'd0, 16'hFFFF));
        send_beat(mk_beat(8'h00, 1'b1, 1'b1, 8'd0, 16'h0000));
    endtask

    task automatic test_short_frames();
        send_beat(mk_beat(8'hFF, 1'b1, 1'b1, 8'd1, 16'h0000));
        send_beat(mk_beat(8'h00, 1'b1, 1'b0, 8'd3, 16'hA55A));
        send_beat(mk_beat(8'hFF, 1'b0, 1'b0, 8'hFF, 16'hFFFF));
        send_beat(mk_beat(8'hA5, 1'b0, 1'b1, 8'h00, 16'h0000));
    endtask

    task automatic test_stray();
        send_beat(mk_beat(8'h5A, 1'b0, 1'b1, 8'h33, 16'h1234));
        send_beat(mk_beat(8'hC3, 1'b0, 1'b0, 8'hFF, 16'hFFFF));
    endtask

    task automatic test_oversize();
        send_frame(8'd101, 16'h8001, 3, 1'b1);
        send_frame(8'd255, 16'hFFFF, 1, 1'b1);
        // largest legal length, closed at once
        send_beat(mk_beat(8'h7F, 1'b1, 1'b1, MAX_PAYLOAD, 16'h00FF));
    endtask

    task automatic test_early_restart();
        send_frame(8'd4, 16'($urandom_range(65535)), 2, 1'b0);
        send_frame(8'd2, 16'($urandom_range(65535)), 2, 1'b1);
        send_frame(8'd200, 16'($urandom_range(65535)), 1, 1'b0);
        send_frame(8'd1, 16'($urandom_range(65535)), 1, 1'b1);
    endtask

    task automatic test_length_mismatch();
        send_frame(8'd2, 16'($urandom_range(65535)), 4, 1'b1);
        send_frame(8'd5, 16'($urandom_range(65535)), 2, 1'b1);
    endtask

    task automatic test_register_extremes();
        drain();
        write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(8'd2, 16'hFFFF, 2, 1'b1);
        drain();
        write_all(8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(8'd0, 16'h0000, 1, 1'b1);
        drain();
        write_all(RST_START_DELIM, RST_FRAME_TYPE, RST_FRAME_ID, RST_TX_OPTIONS);
    endtask

    task automatic test_random_traffic(int sender_idle, int receiver_stall, int n_target);
        drain();
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        write_all(pick_reg_value(), pick_reg_value(), pick_reg_value(), pick_reg_value());
        n_live = 0;
        while (n_live < n_target) begin
            send_random_frame();
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : check_out
        t_out_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_bytes_q.size() == 0) begin
                if (n_mismatch < 10) begin
                    $display("unexpected beat: data %h last %b err %b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
                n_mismatch++;
            end else begin
                want = frame_bytes_q.pop_front();
                if (m_axis_tdata !== want.data || m_axis_tlast !== want.is_last ||
                    m_axis_tuser !== want.err) begin
                    if (n_mismatch < 10) begin
                        $display("beat mismatch: exp data %h last %b err %b, got %h %b %b",
                                 want.data, want.is_last, want.err,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                    n_mismatch++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_START_DELIM;
        i_cfg_data    = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        reg_delim     = RST_START_DELIM;
        reg_type      = RST_FRAME_TYPE;
        reg_id        = RST_FRAME_ID;
        reg_opts      = RST_TX_OPTIONS;
        open_frame    = 1'b0;
        drop_frame    = 1'b0;
        csum_acc      = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct  = 20;
        stall_pct = 30;
        test_defaults();
        test_short_frames();
        test_stray();
        test_oversize();
        test_early_restart();
        test_length_mismatch();
        test_register_extremes();
        test_random_traffic(26, 85, 30);
        test_random_traffic(85, 26, 30);
        test_random_traffic(0, 0, 30);

        drain();
        if (n_mismatch == 0 && frame_bytes_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
